FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers; defining ASSERT_OFF compiles them out.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// The property must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// The condition must never be true at a clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

FILE: rtl/sale_pkg.sv
// ----------------------------------------------------------------------------
// sale_pkg
// Types and fixed widths shared by the sorted array list engine.
// ----------------------------------------------------------------------------
package sale_pkg;

    // Field widths fixed by the interface.
    localparam int KEY_W     = 32;
    localparam int CNT_W     = 7;
    localparam int OP_W      = 3;
    localparam int POS_OUT_W = 6;

    // Largest count that the count field can hold.
    localparam int CNT_MAX = 127;

    // Operation codes carried by an item.
    typedef enum logic [OP_W-1:0] {
        OP_INSERT_AT     = 3'd0,
        OP_INSERT_SORTED = 3'd1,
        OP_DELETE_KEY    = 3'd2,
        OP_FIND_LINEAR   = 3'd3,
        OP_FIND_BINARY   = 3'd4,
        OP_READ_AT       = 3'd5,
        OP_CLEAR         = 3'd6
    } t_opcode;

    // Sequencer states, one-hot.
    typedef enum logic [9:0] {
        S_IDLE    = 10'b00_0000_0001,
        S_BIN_RD  = 10'b00_0000_0010,
        S_BIN_CMP = 10'b00_0000_0100,
        S_LIN_CMP = 10'b00_0000_1000,
        S_UP_RD   = 10'b00_0001_0000,
        S_UP_MV   = 10'b00_0010_0000,
        S_KEY_WR  = 10'b00_0100_0000,
        S_DN_MV   = 10'b00_1000_0000,
        S_RD_WAIT = 10'b01_0000_0000,
        S_SPARE   = 10'b10_0000_0000
    } t_state;

    // Outcome of the shared key comparator.
    typedef struct packed {
        logic eq;
        logic lt;
    } t_cmp;

    // One result item.
    typedef struct packed {
        logic                    success;
        logic [POS_OUT_W-1:0]    position;
        logic signed [KEY_W-1:0] key;
        logic [CNT_W-1:0]        count;
    } t_result;

endpackage

FILE: rtl/sale_cmp.sv
// ----------------------------------------------------------------------------
// sale_cmp
// Shared signed key comparator used by every search step and by the shift of a sorted insert.
// ----------------------------------------------------------------------------
module sale_cmp
    import sale_pkg::*;
(
    input  logic signed [KEY_W-1:0] i_a,
    input  logic signed [KEY_W-1:0] i_b,
    output t_cmp                    o_cmp
);

    // Equality and signed less-than of a against b.
    always_comb begin
        o_cmp.eq = (i_a == i_b);
        o_cmp.lt = (i_a < i_b);
    end

endmodule

FILE: rtl/sale_ctrl.sv
// ----------------------------------------------------------------------------
// sale_ctrl
// Sequencer, key store and element count of the sorted array list engine.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sale_ctrl
    import sale_pkg::*;
#(
    parameter int MAX_DEPTH = 64
)
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic [OP_W-1:0]         i_opcode,
    input  logic signed [KEY_W-1:0] i_key_in,
    input  logic [CNT_W-1:0]        i_position_in,
    input  logic [CNT_W-1:0]        i_eff_cap,
    output logic                    o_busy,
    output logic                    o_res_valid,
    output t_result                 o_res
);

    localparam int AW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
    localparam logic [CNT_W-1:0] DEPTH_CAP =
        CNT_W'((MAX_DEPTH > CNT_MAX) ? CNT_MAX : MAX_DEPTH);

    // Control and working registers.
    t_state                  r_state, n_state;
    t_opcode                 r_op, n_op;
    logic signed [KEY_W-1:0] r_key, n_key;
    logic [CNT_W-1:0]        r_pin, n_pin;
    logic [CNT_W-1:0]        r_idx, n_idx;
    logic [CNT_W-1:0]        r_rpos, n_rpos;
    logic [CNT_W-1:0]        r_lo, n_lo;
    logic [CNT_W-1:0]        r_hip1, n_hip1;
    logic [CNT_W-1:0]        r_count, n_count;

    // Result registers.
    logic                    r_res_valid;
    logic                    r_res_ok;
    logic [CNT_W-1:0]        r_res_pos;
    logic signed [KEY_W-1:0] r_res_key;
    logic [CNT_W-1:0]        r_res_count;

    // Key store and its port controls.
    logic signed [KEY_W-1:0] r_mem [MAX_DEPTH];
    logic signed [KEY_W-1:0] r_rd_data;
    logic                    mem_we;
    logic                    mem_re;
    logic                    wr_key;
    logic [CNT_W-1:0]        raddr_i;
    logic signed [KEY_W-1:0] mem_wdata;

    // Step values.
    logic                    res_fire;
    logic                    res_ok;
    logic [CNT_W-1:0]        res_pos;
    logic signed [KEY_W-1:0] res_key;
    logic [CNT_W:0]          bin_sum;
    logic [CNT_W-1:0]        bin_mid;
    logic [CNT_W:0]          idx_p1;
    logic [CNT_W:0]          idx_p2;
    logic [CNT_W-1:0]        up_lim;
    t_cmp                    cmp;

    // The one comparator: stored key against the item's key.
    sale_cmp u_cmp (
        .i_a   (r_rd_data),
        .i_b   (r_key),
        .o_cmp (cmp)
    );

    // Midpoint of the search window and neighbouring indexes.
    assign bin_sum   = {1'b0, r_lo} + {1'b0, r_hip1} - (CNT_W+1)'(1);
    assign bin_mid   = bin_sum[CNT_W:1];
    assign idx_p1    = {1'b0, r_idx} + (CNT_W+1)'(1);
    assign idx_p2    = {1'b0, r_idx} + (CNT_W+1)'(2);
    assign up_lim    = (r_op == OP_INSERT_AT) ? r_pin : '0;
    assign mem_wdata = wr_key ? r_key : r_rd_data;

    // Sequencer.
    always_comb begin
        n_state  = r_state;
        n_op     = r_op;
        n_key    = r_key;
        n_pin    = r_pin;
        n_idx    = r_idx;
        n_rpos   = r_rpos;
        n_lo     = r_lo;
        n_hip1   = r_hip1;
        n_count  = r_count;
        mem_we   = 1'b0;
        mem_re   = 1'b0;
        wr_key   = 1'b0;
        raddr_i  = r_idx;
        res_fire = 1'b0;
        res_ok   = 1'b0;
        res_pos  = '0;
        res_key  = r_key;

        case (r_state)
            S_IDLE: begin
                res_key = i_key_in;
                if (i_start) begin
                    n_op  = t_opcode'(i_opcode);
                    n_key = i_key_in;
                    n_pin = i_position_in;
                    case (t_opcode'(i_opcode))
                        OP_INSERT_AT: begin
                            if (r_count < i_eff_cap && i_position_in <= r_count) begin
                                n_idx   = r_count;
                                n_state = S_UP_RD;
                            end else begin
                                res_fire = 1'b1;
                            end
                        end
                        OP_INSERT_SORTED: begin
                            if (r_count < i_eff_cap) begin
                                n_lo    = '0;
                                n_hip1  = r_count;
                                n_state = S_BIN_RD;
                            end else begin
                                res_fire = 1'b1;
                            end
                        end
                        OP_DELETE_KEY, OP_FIND_LINEAR: begin
                            if (r_count != '0) begin
                                mem_re  = 1'b1;
                                raddr_i = '0;
                                n_idx   = '0;
                                n_state = S_LIN_CMP;
                            end else begin
                                res_fire = 1'b1;
                            end
                        end
                        OP_FIND_BINARY: begin
                            n_lo    = '0;
                            n_hip1  = r_count;
                            n_state = S_BIN_RD;
                        end
                        OP_READ_AT: begin
                            if (i_position_in < r_count) begin
                                mem_re  = 1'b1;
                                raddr_i = i_position_in;
                                n_state = S_RD_WAIT;
                            end else begin
                                res_fire = 1'b1;
                            end
                        end
                        OP_CLEAR: begin
                            n_count  = '0;
                            res_fire = 1'b1;
                            res_ok   = 1'b1;
                        end
                        default: begin
                            res_fire = 1'b1;
                        end
                    endcase
                end
            end

            // Probe the middle of the window, or end the search.
            S_BIN_RD: begin
                if (r_lo < r_hip1) begin
                    mem_re  = 1'b1;
                    raddr_i = bin_mid;
                    n_idx   = bin_mid;
                    n_state = S_BIN_CMP;
                end else if (r_op == OP_INSERT_SORTED) begin
                    n_idx   = r_count;
                    n_state = S_UP_RD;
                end else begin
                    res_fire = 1'b1;
                end
            end

            // Narrow the window on the probed key.
            S_BIN_CMP: begin
                if (cmp.eq) begin
                    res_fire = 1'b1;
                    if (r_op != OP_INSERT_SORTED) begin
                        res_ok  = 1'b1;
                        res_pos = r_idx;
                    end
                end else begin
                    if (cmp.lt) begin
                        n_lo = idx_p1[CNT_W-1:0];
                    end else begin
                        n_hip1 = r_idx;
                    end
                    n_state = S_BIN_RD;
                end
            end

            // Linear scan, one entry a cycle.
            S_LIN_CMP: begin
                if (cmp.eq) begin
                    if (r_op == OP_DELETE_KEY) begin
                        n_rpos = r_idx;
                        if (idx_p1 < {1'b0, r_count}) begin
                            mem_re  = 1'b1;
                            raddr_i = idx_p1[CNT_W-1:0];
                            n_state = S_DN_MV;
                        end else begin
                            n_count  = r_count - CNT_W'(1);
                            res_fire = 1'b1;
                            res_ok   = 1'b1;
                            res_pos  = r_idx;
                        end
                    end else begin
                        res_fire = 1'b1;
                        res_ok   = 1'b1;
                        res_pos  = r_idx;
                    end
                end else if (idx_p1 < {1'b0, r_count}) begin
                    mem_re  = 1'b1;
                    raddr_i = idx_p1[CNT_W-1:0];
                    n_idx   = idx_p1[CNT_W-1:0];
                end else begin
                    res_fire = 1'b1;
                end
            end

            // Close the gap left by a deleted key, one entry a cycle.
            S_DN_MV: begin
                mem_we = 1'b1;
                n_idx  = idx_p1[CNT_W-1:0];
                if (idx_p2 < {1'b0, r_count}) begin
                    mem_re  = 1'b1;
                    raddr_i = idx_p2[CNT_W-1:0];
                end else begin
                    n_count  = r_count - CNT_W'(1);
                    res_fire = 1'b1;
                    res_ok   = 1'b1;
                    res_pos  = r_rpos;
                end
            end

            // Open a hole: fetch the entry below it.
            S_UP_RD: begin
                if (r_idx > up_lim) begin
                    mem_re  = 1'b1;
                    raddr_i = r_idx - CNT_W'(1);
                    n_state = S_UP_MV;
                end else begin
                    n_state = S_KEY_WR;
                end
            end

            // Move the fetched entry up while it belongs above the new key, or always for an insert at a position.
            S_UP_MV: begin
                if (r_op == OP_INSERT_AT || (!cmp.eq && !cmp.lt)) begin
                    mem_we = 1'b1;
                    n_idx  = r_idx - CNT_W'(1);
                    if ((r_idx - CNT_W'(1)) > up_lim) begin
                        mem_re  = 1'b1;
                        raddr_i = r_idx - CNT_W'(2);
                    end else begin
                        n_state = S_KEY_WR;
                    end
                end else begin
                    n_state = S_KEY_WR;
                end
            end

            // Drop the key into the hole.
            S_KEY_WR: begin
                mem_we   = 1'b1;
                wr_key   = 1'b1;
                n_count  = r_count + CNT_W'(1);
                res_fire = 1'b1;
                res_ok   = 1'b1;
                res_pos  = r_idx;
            end

            S_RD_WAIT: begin
                res_fire = 1'b1;
                res_ok   = 1'b1;
                res_pos  = r_pin;
                res_key  = r_rd_data;
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (res_fire) begin
            n_state = S_IDLE;
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_res_valid <= res_fire;
        end
    end

    // Working and result payload registers.
    always_ff @(posedge i_clk) begin
        r_op   <= n_op;
        r_key  <= n_key;
        r_pin  <= n_pin;
        r_idx  <= n_idx;
        r_rpos <= n_rpos;
        r_lo   <= n_lo;
        r_hip1 <= n_hip1;
        if (res_fire) begin
            r_res_ok    <= res_ok;
            r_res_pos   <= res_pos;
            r_res_key   <= res_key;
            r_res_count <= n_count;
        end
    end

    // Key store: one write and one registered read a cycle.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[AW'(r_idx)] <= mem_wdata;
        end
        if (mem_re) begin
            r_rd_data <= r_mem[AW'(raddr_i)];
        end
    end

    // Outputs.
    assign o_busy           = (r_state != S_IDLE);
    assign o_res_valid      = r_res_valid;
    assign o_res.success    = r_res_ok;
    assign o_res.position   = r_res_pos[POS_OUT_W-1:0];
    assign o_res.key        = r_res_key;
    assign o_res.count      = r_res_count;

    // Checks on the sequencer and the store.
    `ASSERT_NEVER(a_count_cap, i_clk, i_rst_n, r_count > DEPTH_CAP, "count above depth")
    `ASSERT_NEVER(a_wr_range, i_clk, i_rst_n, mem_we && (r_idx > r_count), "write past list end")
    `ASSERT_ALWAYS(a_res_idle, i_clk, i_rst_n, r_res_valid |-> (r_state == S_IDLE), "result while busy")
    `ASSERT_ALWAYS(a_count_res, i_clk, i_rst_n, (r_count != $past(r_count)) |-> (r_res_valid || $past(!i_rst_n)), "count moved without result")
    `ASSERT_ALWAYS(a_res_cause, i_clk, i_rst_n, r_res_valid |-> ($past(r_state != S_IDLE) || $past(i_start)), "result without item")

endmodule

FILE: rtl/sorted_array_list_engine.sv
// ----------------------------------------------------------------------------
// sorted_array_list_engine
// Bounded array list of signed keys with insert, delete, find, read and clear.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low. Exactly one result comes
// back on o_strobe for a single cycle, in the first cycle with busy low after
// the item. The receiver cannot stall, so it must take the result in that cycle.
// Every step goes through the single read port of the key store and the one
// comparator, so the time an item takes follows the work it does:
// - clear and rejected items end in the idle state without raising busy;
// - read passes through one wait state for the registered read;
// - a linear find or a delete scans the keys in order from the first and, for
//   a delete, moves each key above the one found down by one place;
// - a binary find reads and then compares one probe at a time;
// - insert at a position moves each key from the end down to the position up
//   by one place and then writes the key;
// - a sorted insert runs its binary duplicate check and then moves each key
//   that compares above the new key up by one place before it writes the key.
// The longest item is a sorted insert of a new smallest key into a list of 63
// keys: its binary search, 63 moves and the key write. Capacity may only be
// written while busy is low and no result is pending.
// ----------------------------------------------------------------------------
module sorted_array_list_engine
    import sale_pkg::*;
#(
    parameter int MAX_DEPTH = 64
)
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic [OP_W-1:0]         i_opcode,
    input  logic signed [KEY_W-1:0] i_key_in,
    input  logic [CNT_W-1:0]        i_position_in,
    input  logic                    i_cfg_we,
    input  logic [CNT_W-1:0]        i_cfg_wdata,
    output logic                    o_strobe,
    output logic                    o_success,
    output logic [POS_OUT_W-1:0]    o_position_out,
    output logic signed [KEY_W-1:0] o_key_out,
    output logic [CNT_W-1:0]        o_count_out
);

    localparam logic [CNT_W-1:0] DEPTH_CAP =
        CNT_W'((MAX_DEPTH > CNT_MAX) ? CNT_MAX : MAX_DEPTH);
    localparam logic [CNT_W-1:0] CAP_RESET =
        CNT_W'((MAX_DEPTH > 64) ? 64 : MAX_DEPTH);

    logic [CNT_W-1:0] r_eff_cap, n_eff_cap;
    t_result          res;

    // Capacity register, held already limited to the store depth.
    assign n_eff_cap = (i_cfg_wdata < DEPTH_CAP) ? i_cfg_wdata : DEPTH_CAP;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eff_cap <= CAP_RESET;
        end else if (i_cfg_we) begin
            r_eff_cap <= n_eff_cap;
        end
    end

    // Sequencer with the key store.
    sale_ctrl #(
        .MAX_DEPTH (MAX_DEPTH)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (start),
        .i_opcode      (i_opcode),
        .i_key_in      (i_key_in),
        .i_position_in (i_position_in),
        .i_eff_cap     (r_eff_cap),
        .o_busy        (busy),
        .o_res_valid   (o_strobe),
        .o_res         (res)
    );

    // Result fields onto their ports.
    assign o_success      = res.success;
    assign o_position_out = res.position;
    assign o_key_out      = res.key;
    assign o_count_out    = res.count;

endmodule
